>>> rtl/arp_cache_responder_defines.svh
// ----------------------------------------------------------------------------
// ARP cache responder assertion macros
// Shared property wrappers for the top level checks.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH

// implication checked every clock, masked in reset
`define ARPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Types, opcodes and status codes for the ARP cache responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned LIFETIME_RESET = 300;
  localparam int unsigned TICK_MS        = 1000;

  typedef enum logic [2:0] {
    OP_PACKET = 3'd0,
    OP_SET    = 3'd1,
    OP_DELETE = 3'd2,
    OP_STATIC = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_TICK   = 3'd5
  } arpc_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_INVALID  = 3'd2,
    ST_REPLY    = 3'd3,
    ST_FULL     = 3'd4
  } arpc_status_t;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IP = 8'd4;
  localparam logic [15:0] AOP_REQUEST = 16'd1;
  localparam logic [15:0] AOP_REPLY   = 16'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_AGE,
    S_DONE
  } arpc_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key_ip;
    logic [47:0] mac_in;
    logic [31:0] sender_ip_in;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_operation;
    logic        length_ok;
    logic [3:0]  device_index;
  } arpc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] mac_out;
    logic [31:0] reply_sender_ip;
    logic [47:0] reply_target_mac;
    logic [31:0] reply_target_ip;
    logic [3:0]  reply_device;
  } arpc_out_t;

  // slot scan result, one slot per cycle
  typedef struct packed {
    logic hit;
    logic free_found;
  } arpc_scan_t;

endpackage

>>> rtl/arpc_if.sv
// ----------------------------------------------------------------------------
// ARP cache channel interface
// Valid/ready channel carrying one beat of payload type.
// ----------------------------------------------------------------------------
interface arpc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/arpc_table.sv
// ----------------------------------------------------------------------------
// ARP cache slot table
// Per-slot registers with one shared port: slot read, write, clear, static mark, age step.
// ----------------------------------------------------------------------------
module arpc_table #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] idx,
  input  logic          wr_en,
  input  logic [31:0]   wr_ip,
  input  logic [47:0]   wr_mac,
  input  logic          clr_valid,
  input  logic          set_static,
  input  logic          age_en,
  input  logic [15:0]   wr_ticks,
  output logic          rd_valid,
  output logic [31:0]   rd_ip,
  output logic [47:0]   rd_mac
);
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] static_r;
  logic [31:0] ip_r [ENTRIES];
  logic [47:0] mac_r [ENTRIES];
  logic [15:0] ticks_r [ENTRIES];

  assign rd_valid = valid_r[idx];
  assign rd_ip    = ip_r[idx];
  assign rd_mac   = mac_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[idx] <= 1'b1;
    end else if (clr_valid) begin
      valid_r[idx] <= 1'b0;
    end else if (age_en && valid_r[idx] && !static_r[idx] && ticks_r[idx] <= 16'd1) begin
      valid_r[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_r[idx]     <= wr_ip;
      mac_r[idx]    <= wr_mac;
      static_r[idx] <= 1'b0;
      ticks_r[idx]  <= wr_ticks;
    end else if (set_static) begin
      static_r[idx] <= 1'b1;
    end else if (age_en && valid_r[idx] && !static_r[idx] && ticks_r[idx] > 16'd1) begin
      ticks_r[idx] <= ticks_r[idx] - 16'd1;
    end
  end
endmodule

>>> rtl/arp_cache_responder.sv
// Bad packets, response packets and unknown opcodes go from scan straight to done;
// ticks and table operations step the slots one per cycle.
// Throughput: one item at a time, ready only in idle; a new beat is taken in
// the cycle its predecessor's result is presented. Done waits while an untaken
// result sits in the output register. Reset clears valid bits and control;
// lifetime is 300.
// ----------------------------------------------------------------------------
// ARP cache responder top level
// Sequencer over the slot table: search, set, delete, mark, lookup, age.
// ----------------------------------------------------------------------------
module arp_cache_responder #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  arpc_if.sink        in_ch,
  arpc_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import arpc_pkg::*;
  `include "arp_cache_responder_defines.svh"

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  arpc_state_t state_r, state_nxt;
  arpc_in_t    item_r;
  arpc_out_t   res_r, res_nxt;
  arpc_out_t   out_r;
  logic        out_valid_r;
  logic        out_load;
  logic [15:0] life_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  arpc_scan_t  found_r, found_nxt;
  logic [IW-1:0] hit_idx_nxt, free_idx_nxt;

  logic [IW-1:0] t_idx;
  logic t_wr, t_clr, t_stat, t_age, rd_valid;
  logic [31:0] rd_ip;
  logic [47:0] rd_mac;
  logic pkt_ok;

  arpc_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
    .clk, .rst_n, .idx(t_idx), .wr_en(t_wr), .wr_ip(item_r.key_ip),
    .wr_mac(item_r.mac_in), .clr_valid(t_clr), .set_static(t_stat),
    .age_en(t_age), .wr_ticks(life_r), .rd_valid, .rd_ip, .rd_mac
  );

  assign pkt_ok = item_r.length_ok && item_r.hw_type == HW_ETHERNET &&
                  item_r.proto_type == PROTO_IPV4 && item_r.hw_len == HW_LEN_ETH &&
                  item_r.proto_len == PROTO_LEN_IP &&
                  (item_r.arp_operation == AOP_REQUEST || item_r.arp_operation == AOP_REPLY);

  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= 16'(LIFETIME_RESET);
    end else if (cfg_we) begin
      life_r <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_SCAN;
      S_SCAN: begin
        if (item_r.opcode == OP_TICK) state_nxt = S_AGE;
        else if (item_r.opcode > OP_TICK) state_nxt = S_DONE;
        else if (item_r.opcode == OP_PACKET &&
                 (!pkt_ok || item_r.arp_operation != AOP_REQUEST)) state_nxt = S_DONE;
        else if (cnt_r == CW'(ENTRIES - 1)) state_nxt = S_APPLY;
      end
      S_AGE:   if (cnt_r == CW'(ENTRIES - 1)) state_nxt = S_DONE;
      S_APPLY: state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    res_nxt      = res_r;
    t_idx = cnt_r[IW-1:0];
    t_wr = 1'b0; t_clr = 1'b0; t_stat = 1'b0; t_age = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt   = '0;
        found_nxt = '0;
        res_nxt   = '0;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (rd_valid && rd_ip == item_r.key_ip && !found_r.hit) begin
          found_nxt.hit = 1'b1;
          hit_idx_nxt   = cnt_r[IW-1:0];
        end
        if (!rd_valid && !found_r.free_found) begin
          found_nxt.free_found = 1'b1;
          free_idx_nxt         = cnt_r[IW-1:0];
        end
        if (item_r.opcode > OP_TICK) res_nxt.status = ST_INVALID;
        else if (item_r.opcode == OP_PACKET && !pkt_ok) res_nxt.status = ST_INVALID;
        else if (item_r.opcode == OP_TICK) cnt_nxt = '0;
      end
      S_AGE: begin
        t_age   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
      end
      S_APPLY: begin
        t_idx = hit_idx_r;
        case (item_r.opcode)
          OP_PACKET: begin
            if (found_r.hit) begin
              res_nxt.status           = ST_REPLY;
              res_nxt.mac_out          = rd_mac;
              res_nxt.reply_sender_ip  = rd_ip;
              res_nxt.reply_target_mac = item_r.mac_in;
              res_nxt.reply_target_ip  = item_r.sender_ip_in;
              res_nxt.reply_device     = item_r.device_index;
            end else begin
              res_nxt.status = ST_NOTFOUND;
            end
          end
          OP_SET: begin
            if (found_r.hit) begin
              t_wr = 1'b1;
            end else if (found_r.free_found) begin
              t_idx = free_idx_r;
              t_wr  = 1'b1;
            end else begin
              res_nxt.status = ST_FULL;
            end
          end
          OP_DELETE: begin
            if (found_r.hit) t_clr = 1'b1;
            else res_nxt.status = ST_NOTFOUND;
          end
          OP_STATIC: begin
            if (found_r.hit) t_stat = 1'b1;
            else res_nxt.status = ST_NOTFOUND;
          end
          OP_LOOKUP: begin
            if (found_r.hit) res_nxt.mac_out = rd_mac;
            else res_nxt.status = ST_NOTFOUND;
          end
          default: res_nxt.status = ST_INVALID;
        endcase
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      found_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
    if (out_load) out_r <= res_r;
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
  end

  `ARPC_ASSERT_IMP(a_ready_idle, in_ch.ready, state_r == S_IDLE,
    "ready outside idle")
  `ARPC_ASSERT_NEXT(a_done_valid, state_r == S_DONE, out_valid_r,
    "result not presented after done")
  `ARPC_ASSERT_IMP(a_one_write, t_wr, !t_clr && !t_stat && !t_age,
    "conflicting table commands")
  `ARPC_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_r),
    "result beat changed while waiting")
endmodule
